// ===== sv/mdds_pkg.sv =====
// ---------------------------------------------------------------------------
// mdds_pkg: shared types, constants and sine table
// Types, codes and the quarter-wave sine table of the multitone DDS block.
// ---------------------------------------------------------------------------
`default_nettype none

package mdds_pkg;

    // Geometry
    localparam int TONE_SLOTS  = 8;
    localparam int SLOT_W      = $clog2(TONE_SLOTS);
    localparam int CNT_W       = $clog2(TONE_SLOTS + 1);
    localparam int TAB_ENTRIES = 512;
    localparam int TAB_BITS    = $clog2(TAB_ENTRIES);
    localparam int FRAC_BITS   = 15 - TAB_BITS;
    localparam int QTR         = TAB_ENTRIES / 4;
    localparam int QTR_BITS    = $clog2(QTR);

    // Field and register widths
    localparam int PH_W   = 16;
    localparam int FREQ_W = 27;
    localparam int AMP_W  = 16;
    localparam int MV_W   = 16;
    localparam int TC_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 27;
    localparam int TERM_W = 18;
    localparam int SUM_W  = 22;

    // Divider geometry: (freq << 16) / sample_rate is the widest case
    localparam int DIV_DVD_W = FREQ_W + PH_W;
    localparam int DIV_DSR_W = FREQ_W;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

    // Register reset values
    localparam logic [FREQ_W-1:0] RST_SAMPLE_RATE = FREQ_W'(48000);
    localparam logic [MV_W-1:0]   RST_VREF        = MV_W'(3300);
    localparam logic [MV_W-1:0]   RST_ADC_MAX     = MV_W'(4095);

    // Commands
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE = 3'd0,
        REG_DC_OFFSET   = 3'd1,
        REG_VREF        = 3'd2,
        REG_ADC_MAX     = 3'd3,
        REG_TONE_COUNT  = 3'd4
    } t_reg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WDIV,
        ST_RUN,
        ST_DRAIN,
        ST_CDIV,
        ST_OUT
    } t_state;

    // State of one tone slot
    typedef struct packed {
        logic [PH_W-1:0]  accum;
        logic [PH_W-1:0]  step;
        logic [AMP_W-1:0] amp;
    } t_tone;

    // Control of the tone cell row
    typedef struct packed {
        logic shift;
        logic clr;
        logic wr;
    } t_cell_ctl;

    // Quarter-wave table, Q15, 0 .. 32768
    typedef logic [16:0] t_qtab [0:QTR];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // sin(pi/2 * j / QTR) by a nested series, evaluated at elaboration
    function automatic logic [16:0] quarter_sine(input int j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        x   = (HALF_PI_Q30 * 64'(j)) >> QTR_BITS;
        x2  = (x * x) >> 30;
        acc = ONE_Q30;
        acc = ONE_Q30 - (((x2 * acc) >> 30) / 156);
        acc = ONE_Q30 - (((x2 * acc) >> 30) / 110);
        acc = ONE_Q30 - (((x2 * acc) >> 30) / 72);
        acc = ONE_Q30 - (((x2 * acc) >> 30) / 42);
        acc = ONE_Q30 - (((x2 * acc) >> 30) / 20);
        acc = ONE_Q30 - (((x2 * acc) >> 30) / 6);
        acc = (x * acc) >> 30;
        return 17'((acc + 64'd16384) >> 15);
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int j = 0; j <= QTR; j++) begin
            t[j] = quarter_sine(j);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    // Full-wave entry i (0 .. TAB_ENTRIES) from the quarter table, saturated
    function automatic logic signed [15:0] sine_entry(input logic [TAB_BITS:0] i);
        logic [2:0]          quad;
        logic [QTR_BITS-1:0] r;
        logic [16:0]         q;
        logic [QTR_BITS:0]   mir;
        logic signed [15:0]  v;
        quad = 3'(i >> QTR_BITS);
        r    = i[QTR_BITS-1:0];
        mir  = (QTR_BITS+1)'(QTR) - {1'b0, r};
        q    = (quad == 3'd1 || quad == 3'd3) ? QTAB[mir] : QTAB[r];
        case (quad)
            3'd0, 3'd1: v = (q > 17'd32767) ? 16'sd32767 : $signed(q[15:0]);
            3'd2, 3'd3: v = $signed(16'(~q + 17'd1));
            default:    v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mdds_cell.sv =====
// ---------------------------------------------------------------------------
// mdds_cell: one tone slot of the cell row
// Holds phase accumulator, phase step and amplitude; shifts to its neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module mdds_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mdds_pkg::t_cell_ctl          i_ctl,
    input  wire                          i_sel,
    input  wire  [mdds_pkg::PH_W-1:0]    i_wr_step,
    input  wire  [mdds_pkg::AMP_W-1:0]   i_wr_amp,
    input  mdds_pkg::t_tone              i_next,
    output mdds_pkg::t_tone              o_tone
);

    mdds_pkg::t_tone r_tone;
    mdds_pkg::t_tone n_tone;

    // shift wins; write and restart only happen while the row sits at home
    always_comb begin
        n_tone = r_tone;
        if (i_ctl.shift) begin
            n_tone = i_next;
        end else if (i_ctl.clr) begin
            n_tone.accum = '0;
        end else if (i_ctl.wr && i_sel) begin
            n_tone.step = i_wr_step;
            n_tone.amp  = i_wr_amp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone <= '0;
        end else begin
            r_tone <= n_tone;
        end
    end

    assign o_tone = r_tone;

endmodule

`default_nettype wire

// ===== sv/mdds_sine.sv =====
// ---------------------------------------------------------------------------
// mdds_sine: interpolated sine lookup and amplitude scaling
// Four-stage pipeline from phase accumulator to scaled signed term.
// ---------------------------------------------------------------------------
`default_nettype none

module mdds_sine (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire  [mdds_pkg::PH_W-1:0]            i_accum,
    input  wire  [mdds_pkg::AMP_W-1:0]           i_amp,
    output logic                                 o_valid,
    output logic signed [mdds_pkg::TERM_W-1:0]   o_term,
    output logic                                 o_busy
);

    localparam int FB = mdds_pkg::FRAC_BITS;
    localparam int TB = mdds_pkg::TAB_BITS;

    logic [14:0]        x;
    logic [TB-1:0]      idx;
    logic [14:0]        f;

    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [15:0] r_a, r_b;
    logic [14:0]        r_f;
    logic [15:0]        r_amp1, r_amp2, r_amp3;
    logic signed [33:0] r_p1;
    logic signed [31:0] r_p2;
    logic signed [15:0] r_s;
    logic signed [mdds_pkg::TERM_W-1:0] r_term;

    logic [16:0]        one_m_f;
    logic [15:0]        u;
    logic signed [32:0] prod;

    // stage 1: table address and fraction
    assign x   = i_accum[15:1];
    assign idx = x[14:FB];
    assign f   = 15'({x[FB-1:0]} << (15 - FB));

    // stage 2 operands
    assign one_m_f = 17'd32768 - {2'b0, r_f};

    // stage 3: interpolation sum, wrapped to 16 bits, then doubled
    assign u = r_p1[31:16] + r_p2[31:16];

    // stage 4: scale by amplitude
    assign prod = r_s * $signed({1'b0, r_amp3});

    always_ff @(posedge i_clk) begin
        r_a    <= mdds_pkg::sine_entry({1'b0, idx});
        r_b    <= mdds_pkg::sine_entry({1'b0, idx} + (TB+1)'(1));
        r_f    <= f;
        r_amp1 <= i_amp;
        r_p1   <= $signed({1'b0, one_m_f}) * r_a;
        r_p2   <= $signed({1'b0, r_f}) * r_b;
        r_amp2 <= r_amp1;
        r_s    <= $signed({u[14:0], 1'b0});
        r_amp3 <= r_amp2;
        r_term <= prod[32:15];
    end

    // valid tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_term  = r_term;
    assign o_busy  = r_v1 | r_v2 | r_v3 | r_v4;

endmodule

`default_nettype wire

// ===== sv/mdds_div.sv =====
// ---------------------------------------------------------------------------
// mdds_div: restoring divider, one quotient bit per cycle
// Shared by the phase step and the ADC code conversion; low 16 bits out.
// ---------------------------------------------------------------------------
`default_nettype none

module mdds_div (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire  [mdds_pkg::DIV_DVD_W-1:0]     i_dividend,
    input  wire  [mdds_pkg::DIV_DSR_W-1:0]     i_divisor,
    output logic                               o_done,
    output logic [15:0]                        o_quot
);

    localparam int DW = mdds_pkg::DIV_DVD_W;
    localparam int SW = mdds_pkg::DIV_DSR_W;
    localparam int CW = mdds_pkg::DIV_CNT_W;

    logic [DW-1:0] r_dvd;
    logic [SW-1:0] r_dsr;
    logic [SW-1:0] r_rem;
    logic [15:0]   r_q;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [SW:0]   rem_sh;
    logic          ge;
    logic [SW:0]   diff;

    // one restoring step
    assign rem_sh = {r_rem, r_dvd[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};
    assign diff   = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= ge ? diff[SW-1:0] : rem_sh[SW-1:0];
            r_q   <= {r_q[14:0], ge};
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== sv/multitone_dds_adc_code_gen_top.sv =====
// ---------------------------------------------------------------------------
// multitone_dds_adc_code_gen_top: multi-tone DDS producing ADC codes
// Eight tone cells in a ring, a shared sine pipeline and a shared divider.
// ---------------------------------------------------------------------------
// One item at a time. A tick rotates the tone cell ring past the sine pipeline,
// feeding it the active tones, drains it, then runs the bit-serial divider for
// the code conversion (skipped with a zero vref).
// A write-tone beat waits on the same divider working out the phase step
// (skipped with a zero sample rate); a restart beat clears the accumulators
// as it is taken. A finished code waits in the output register while the
// next input beat is taken. The configuration port is always ready and is to
// be written while idle.
`default_nettype none

module multitone_dds_adc_code_gen_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input beats
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [1:0]                          i_command,
    input  wire  [2:0]                          i_tone_index,
    input  wire  [mdds_pkg::FREQ_W-1:0]         i_tone_freq,
    input  wire  [mdds_pkg::AMP_W-1:0]          i_tone_amp,
    // result beats
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [15:0]                         o_adc_code,
    // configuration writes
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mdds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [mdds_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int NS = mdds_pkg::TONE_SLOTS;
    localparam int SW = mdds_pkg::SLOT_W;
    localparam int CW = mdds_pkg::CNT_W;

    // configuration registers
    logic [mdds_pkg::FREQ_W-1:0] r_sample_rate;
    logic [mdds_pkg::MV_W-1:0]   r_dc_offset;
    logic [mdds_pkg::MV_W-1:0]   r_vref;
    logic [mdds_pkg::MV_W-1:0]   r_adc_max;
    logic [mdds_pkg::TC_W-1:0]   r_tone_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= mdds_pkg::RST_SAMPLE_RATE;
            r_dc_offset   <= '0;
            r_vref        <= mdds_pkg::RST_VREF;
            r_adc_max     <= mdds_pkg::RST_ADC_MAX;
            r_tone_count  <= '0;
        end else if (i_cfg_valid) begin
            case (mdds_pkg::t_reg'(i_cfg_index))
                mdds_pkg::REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                mdds_pkg::REG_DC_OFFSET:   r_dc_offset   <= i_cfg_data[15:0];
                mdds_pkg::REG_VREF:        r_vref        <= i_cfg_data[15:0];
                mdds_pkg::REG_ADC_MAX:     r_adc_max     <= i_cfg_data[15:0];
                mdds_pkg::REG_TONE_COUNT:  r_tone_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer registers
    mdds_pkg::t_state r_state, n_state;
    logic [SW-1:0]             r_cnt;
    logic [SW-1:0]             r_slot;
    logic [mdds_pkg::AMP_W-1:0] r_amp;
    logic signed [mdds_pkg::SUM_W-1:0] r_sum;
    logic [15:0]               r_code;
    logic [15:0]               r_out_code;
    logic                      r_out_valid;

    logic in_acc;
    mdds_pkg::t_cmd cmd;
    assign in_acc = i_in_valid && o_in_ready;
    assign cmd    = mdds_pkg::t_cmd'(i_command);

    // active tone count, capped at the slot count
    logic [CW-1:0] active_n;
    assign active_n = (r_tone_count > mdds_pkg::TC_W'(NS)) ? CW'(NS) : CW'(r_tone_count);

    // cell ring
    mdds_pkg::t_tone   tone [NS];
    mdds_pkg::t_tone   head_upd;
    mdds_pkg::t_cell_ctl cell_ctl;
    logic [15:0]       wr_step;
    logic              slot_active;

    assign slot_active   = {1'b0, r_cnt} < active_n;
    assign head_upd.step = tone[0].step;
    assign head_upd.amp  = tone[0].amp;
    assign head_upd.accum = slot_active ? (tone[0].accum + tone[0].step) : tone[0].accum;

    for (genvar k = 0; k < NS; k++) begin : g_cell
        mdds_pkg::t_tone nxt;
        if (k == NS - 1) begin : g_last
            assign nxt = head_upd;
        end else begin : g_mid
            assign nxt = tone[k+1];
        end
        mdds_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_sel     (r_slot == SW'(k)),
            .i_wr_step (wr_step),
            .i_wr_amp  (r_amp),
            .i_next    (nxt),
            .o_tone    (tone[k])
        );
    end

    // sine pipeline
    logic sine_valid;
    logic signed [mdds_pkg::TERM_W-1:0] term;
    logic sine_busy;
    logic sine_in_valid;

    mdds_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sine_in_valid),
        .i_accum (head_upd.accum),
        .i_amp   (tone[0].amp),
        .o_valid (sine_valid),
        .o_term  (term),
        .o_busy  (sine_busy)
    );

    // divider
    logic                            div_start;
    logic [mdds_pkg::DIV_DVD_W-1:0]  div_dvd;
    logic [mdds_pkg::DIV_DSR_W-1:0]  div_dsr;
    logic                            div_done;
    logic [15:0]                     div_q;

    mdds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // clamp the sum to [0, vref] and form the rounded code dividend
    logic [15:0] clamped;
    logic [32:0] code_dvd;
    always_comb begin
        if (r_sum < 0) begin
            clamped = '0;
        end else if (r_sum > $signed({6'b0, r_vref})) begin
            clamped = r_vref;
        end else begin
            clamped = r_sum[15:0];
        end
        code_dvd = 33'(clamped) * 33'(r_adc_max) + 33'(r_vref >> 1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mdds_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (cmd == mdds_pkg::CMD_TICK) begin
                        n_state = mdds_pkg::ST_RUN;
                    end else if (cmd == mdds_pkg::CMD_WRITE) begin
                        n_state = mdds_pkg::ST_WDIV;
                    end
                end
            end
            mdds_pkg::ST_WDIV: begin
                if (div_done || r_sample_rate == '0) n_state = mdds_pkg::ST_IDLE;
            end
            mdds_pkg::ST_RUN: begin
                if (r_cnt == SW'(NS - 1)) n_state = mdds_pkg::ST_DRAIN;
            end
            mdds_pkg::ST_DRAIN: begin
                if (!sine_busy) begin
                    n_state = (r_vref == '0) ? mdds_pkg::ST_OUT : mdds_pkg::ST_CDIV;
                end
            end
            mdds_pkg::ST_CDIV: begin
                if (div_done) n_state = mdds_pkg::ST_OUT;
            end
            mdds_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) n_state = mdds_pkg::ST_IDLE;
            end
            default: n_state = mdds_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready    = 1'b0;
        cell_ctl      = '0;
        wr_step       = div_q;
        sine_in_valid = 1'b0;
        div_start     = 1'b0;
        div_dvd       = {i_tone_freq, 16'b0};
        div_dsr       = r_sample_rate;
        case (r_state)
            mdds_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc && cmd == mdds_pkg::CMD_RESTART) cell_ctl.clr = 1'b1;
                if (in_acc && cmd == mdds_pkg::CMD_WRITE && r_sample_rate != '0) begin
                    div_start = 1'b1;
                end
            end
            mdds_pkg::ST_WDIV: begin
                if (r_sample_rate == '0) begin
                    // zero rate: step written as zero once slot and amplitude are held
                    cell_ctl.wr = 1'b1;
                    wr_step     = '0;
                end else begin
                    cell_ctl.wr = div_done;
                end
            end
            mdds_pkg::ST_RUN: begin
                cell_ctl.shift = 1'b1;
                sine_in_valid  = slot_active;
            end
            mdds_pkg::ST_DRAIN: begin
                div_dvd = mdds_pkg::DIV_DVD_W'(code_dvd);
                div_dsr = mdds_pkg::DIV_DSR_W'(r_vref);
                div_start = !sine_busy && (r_vref != '0);
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == mdds_pkg::ST_IDLE && in_acc) begin
            r_slot <= i_tone_index;
            r_amp  <= i_tone_amp;
        end
        if (r_state == mdds_pkg::ST_IDLE) begin
            r_sum <= $signed({6'b0, r_dc_offset});
        end else if (sine_valid) begin
            r_sum <= r_sum + mdds_pkg::SUM_W'(term);
        end
        if (r_state == mdds_pkg::ST_DRAIN) begin
            r_code <= '0;
        end else if (r_state == mdds_pkg::ST_CDIV && div_done) begin
            r_code <= div_q;
        end
        if (r_state == mdds_pkg::ST_OUT && (!r_out_valid || i_out_ready)) begin
            r_out_code <= r_code;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdds_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == mdds_pkg::ST_RUN) ? r_cnt + SW'(1) : '0;
            if (r_state == mdds_pkg::ST_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_adc_code  = r_out_code;

endmodule

`default_nettype wire
